FILE: sv/gbbd_pkg.sv
// Shared types and constants for the grid box-blur diffuser.
// Holds the sequencer state type, command and register codes, and field layout.
// Depends on nothing; used by grid_box_blur_diffuser_top.
package gbbd_pkg;

   // Field widths fixed by the request and response formats.
   localparam int CMD_W      = 2;
   localparam int COORD_W    = 5;
   localparam int LIGHT_W    = 8;
   localparam int CFG_W      = 6;
   localparam int CSR_IDX_W  = 4;

   // Request tdata layout, lowest bit first: cell_x, cell_y, light_value.
   localparam int REQ_X_LSB     = 0;
   localparam int REQ_Y_LSB     = REQ_X_LSB + COORD_W;
   localparam int REQ_LIGHT_LSB = REQ_Y_LSB + COORD_W;
   localparam int REQ_DATA_W    = 24;

   // Width used for signed neighbor coordinate arithmetic and dimension compares.
   localparam int CALC_W = 10;

   typedef enum logic [CMD_W-1:0] {
      CMD_WRITE   = 2'd0,
      CMD_DIFFUSE = 2'd1,
      CMD_READ    = 2'd2
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_GRID_WIDTH  = 4'd0,
      REG_GRID_HEIGHT = 4'd1
   } reg_index_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_READ,
      S_COPY,
      S_CENTER,
      S_WIN,
      S_TAIL,
      S_DIV,
      S_DONE
   } state_type;

endpackage

FILE: sv/grid_box_blur_diffuser_top.sv
// Grid box-blur diffuser: a grid of 8-bit light levels with a diffuse pass.
// Uses gbbd_pkg for the state type, command and register codes and field layout.
// Contains the cell memories, the sequencer and the shared add/subtract unit.

// After reset the block clears the light memory, one cell per cycle, and
// accepts no request until that pass is over; configuration writes are
// taken at any time. A write request is done in the idle state. A read
// request passes through a read state, since the light memory has a
// registered read port, and its response waits in an output register until
// it is taken. A diffuse request first copies the whole light memory into
// the snapshot memory, then visits every cell of the grid in use: a center
// read, (2*RADIUS)^2 window reads through the single snapshot read port, a
// tail step to add the last tap, and restoring division on the shared adder.
// Then the done response is posted. Window taps outside the grid are still
// stepped through but are not summed or counted. The center cell is summed
// twice, once as the start value and once as a window tap. While a read or
// diffuse runs, req_tready is low. Widths or heights above the parameter
// limits are clamped to them, and a zero dimension makes every write a no-op
// and every read answer zero.
module grid_box_blur_diffuser_top #(
   parameter int MAX_WIDTH  = 32,
   parameter int MAX_HEIGHT = 32,
   parameter int RADIUS     = 2
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // Request channel.
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [gbbd_pkg::REQ_DATA_W-1:0]       req_tdata,  // cell_x, cell_y, light_value
   input  logic [gbbd_pkg::CMD_W-1:0]            req_tuser,  // command
   // Response channel.
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [gbbd_pkg::LIGHT_W-1:0]          rsp_tdata,  // read_value
   output logic                                  rsp_tuser,  // diffuse_done
   // Configuration write channel.
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [gbbd_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [gbbd_pkg::CFG_W-1:0]            csr_data
);

   localparam int CELLS  = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW     = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int SW     = $clog2(CELLS + 1);
   localparam int XW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int YW     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int CW     = gbbd_pkg::CALC_W;
   localparam int LW     = gbbd_pkg::LIGHT_W;
   localparam int SPAN   = 2 * RADIUS;
   localparam int TAP_W  = $clog2(SPAN);
   localparam int TAPS   = SPAN * SPAN + 1;
   localparam int CNT_W  = $clog2(TAPS + 1);
   localparam int SUM_W  = LW + CNT_W;
   localparam int DW     = SUM_W + LW;
   localparam int STEP_W = $clog2(LW);

   // Cell memories.
   logic [LW-1:0] light_mem [CELLS];
   logic [LW-1:0] snap_mem  [CELLS];

   gbbd_pkg::state_type state_ff, state_in;

   logic [gbbd_pkg::CFG_W-1:0] width_ff, height_ff;
   logic [SW-1:0]    sweep_ff, sweep_in;
   logic             copy_pend_ff, copy_pend_in;
   logic [AW-1:0]    copy_addr_ff, copy_addr_in;
   logic             hit_ff, hit_in;
   logic [XW-1:0]    cx_ff, cx_in;
   logic [YW-1:0]    cy_ff, cy_in;
   logic [TAP_W-1:0] dxi_ff, dxi_in, dyi_ff, dyi_in;
   logic             pend_ff, pend_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [LW-1:0]    quo_ff, quo_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic             rsp_tvalid_ff, rsp_tvalid_in;
   logic [LW-1:0]    rsp_tdata_ff, rsp_tdata_in;
   logic             rsp_tuser_ff, rsp_tuser_in;

   logic [LW-1:0]    light_rd_ff, snap_rd_ff;

   // Memory port controls.
   logic             light_we, light_re, snap_we, snap_re;
   logic [AW-1:0]    light_waddr, light_raddr, snap_waddr, snap_raddr;
   logic [LW-1:0]    light_wdata;

   // Shared add/subtract unit; bit DW of the result is the carry, which on a
   // subtract means no borrow (a >= b).
   logic [DW-1:0]    alu_a, alu_b;
   logic             alu_sub;
   logic [DW:0]      alu_res;

   logic [CW-1:0]    eff_w, eff_h, nx, ny, req_x, req_y;
   logic             req_hit, nb_hit, rsp_free;
   logic [LW-1:0]    req_light;

   function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] ax,
                                               input logic [CW-1:0] ay);
      logic [31:0] lin;
      lin = 32'(ay) * 32'(MAX_WIDTH) + 32'(ax);
      return lin[AW-1:0];
   endfunction

   assign alu_res = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} + (DW+1)'(alu_sub);

   // Dimensions in use, clamped to the storage limits.
   assign eff_w = (CW'(width_ff) > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : CW'(width_ff);
   assign eff_h = (CW'(height_ff) > CW'(MAX_HEIGHT)) ? CW'(MAX_HEIGHT) : CW'(height_ff);

   assign req_x     = CW'(req_tdata[gbbd_pkg::REQ_X_LSB +: gbbd_pkg::COORD_W]);
   assign req_y     = CW'(req_tdata[gbbd_pkg::REQ_Y_LSB +: gbbd_pkg::COORD_W]);
   assign req_light = req_tdata[gbbd_pkg::REQ_LIGHT_LSB +: LW];
   assign req_hit   = (req_x < eff_w) && (req_y < eff_h);

   // Window neighbor; a negative coordinate shows up as the top bit set.
   assign nx = CW'(cx_ff) + CW'(dxi_ff) - CW'(RADIUS);
   assign ny = CW'(cy_ff) + CW'(dyi_ff) - CW'(RADIUS);
   assign nb_hit = !nx[CW-1] && !ny[CW-1] && (nx < eff_w) && (ny < eff_h);

   assign rsp_free = !rsp_tvalid_ff || rsp_tready;

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign csr_ready  = 1'b1;

   always_comb begin
      state_in      = state_ff;
      sweep_in      = sweep_ff;
      copy_pend_in  = copy_pend_ff;
      copy_addr_in  = copy_addr_ff;
      hit_in        = hit_ff;
      cx_in         = cx_ff;
      cy_in         = cy_ff;
      dxi_in        = dxi_ff;
      dyi_in        = dyi_ff;
      pend_in       = pend_ff;
      sum_in        = sum_ff;
      cnt_in        = cnt_ff;
      quo_in        = quo_ff;
      step_in       = step_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;

      req_tready  = 1'b0;
      light_we    = 1'b0;
      light_waddr = cell_addr(req_x, req_y);
      light_wdata = req_light;
      light_re    = 1'b0;
      light_raddr = cell_addr(req_x, req_y);
      snap_we     = 1'b0;
      snap_waddr  = copy_addr_ff;
      snap_re     = 1'b0;
      snap_raddr  = cell_addr(CW'(cx_ff), CW'(cy_ff));
      alu_a       = DW'(sum_ff);
      alu_b       = DW'(snap_rd_ff);
      alu_sub     = 1'b0;

      unique case (state_ff)
         gbbd_pkg::S_CLEAR: begin
            light_we    = 1'b1;
            light_waddr = AW'(sweep_ff);
            light_wdata = '0;
            sweep_in    = sweep_ff + 1'b1;
            if (sweep_ff == SW'(CELLS - 1)) begin
               state_in = gbbd_pkg::S_IDLE;
            end
         end

         gbbd_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               case (req_tuser)
                  gbbd_pkg::CMD_WRITE: begin
                     light_we = req_hit;
                  end
                  gbbd_pkg::CMD_DIFFUSE: begin
                     sweep_in     = '0;
                     copy_pend_in = 1'b0;
                     state_in     = gbbd_pkg::S_COPY;
                  end
                  gbbd_pkg::CMD_READ: begin
                     light_re = req_hit;
                     hit_in   = req_hit;
                     state_in = gbbd_pkg::S_READ;
                  end
                  default: begin
                  end
               endcase
            end
         end

         gbbd_pkg::S_READ: begin
            if (rsp_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = hit_ff ? light_rd_ff : '0;
               rsp_tuser_in  = 1'b0;
               state_in      = gbbd_pkg::S_IDLE;
            end
         end

         // Copy the light memory into the snapshot, one read and one write
         // per cycle, each write following its read in the next cycle.
         gbbd_pkg::S_COPY: begin
            snap_we = copy_pend_ff;
            if (sweep_ff < SW'(CELLS)) begin
               light_re     = 1'b1;
               light_raddr  = AW'(sweep_ff);
               copy_pend_in = 1'b1;
               copy_addr_in = AW'(sweep_ff);
               sweep_in     = sweep_ff + 1'b1;
            end else begin
               copy_pend_in = 1'b0;
               cx_in        = '0;
               cy_in        = '0;
               if (eff_w == '0 || eff_h == '0) begin
                  state_in = gbbd_pkg::S_DONE;
               end else begin
                  state_in = gbbd_pkg::S_CENTER;
               end
            end
         end

         gbbd_pkg::S_CENTER: begin
            snap_re  = 1'b1;
            pend_in  = 1'b1;
            sum_in   = '0;
            cnt_in   = '0;
            dxi_in   = '0;
            dyi_in   = '0;
            state_in = gbbd_pkg::S_WIN;
         end

         // Each cycle adds the tap read in the previous cycle and issues the
         // next window read.
         gbbd_pkg::S_WIN: begin
            if (pend_ff) begin
               sum_in = SUM_W'(alu_res);
               cnt_in = cnt_ff + 1'b1;
            end
            snap_re    = nb_hit;
            snap_raddr = cell_addr(nx, ny);
            pend_in    = nb_hit;
            dyi_in     = dyi_ff + 1'b1;
            if (dyi_ff == TAP_W'(SPAN - 1)) begin
               dyi_in = '0;
               dxi_in = dxi_ff + 1'b1;
               if (dxi_ff == TAP_W'(SPAN - 1)) begin
                  state_in = gbbd_pkg::S_TAIL;
               end
            end
         end

         gbbd_pkg::S_TAIL: begin
            if (pend_ff) begin
               sum_in = SUM_W'(alu_res);
               cnt_in = cnt_ff + 1'b1;
            end
            quo_in   = '0;
            step_in  = STEP_W'(LW - 1);
            state_in = gbbd_pkg::S_DIV;
         end

         // Restoring division of the sum by the count, one quotient bit a
         // cycle, most significant first. The sum register keeps the remainder.
         gbbd_pkg::S_DIV: begin
            alu_b   = DW'(cnt_ff) << step_ff;
            alu_sub = 1'b1;
            if (alu_res[DW]) begin
               sum_in          = SUM_W'(alu_res[DW-1:0]);
               quo_in[step_ff] = 1'b1;
            end
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               light_we    = 1'b1;
               light_waddr = cell_addr(CW'(cx_ff), CW'(cy_ff));
               light_wdata = quo_ff | LW'(alu_res[DW]);
               state_in    = gbbd_pkg::S_CENTER;
               if (CW'(cy_ff) + 1'b1 < eff_h) begin
                  cy_in = cy_ff + 1'b1;
               end else begin
                  cy_in = '0;
                  if (CW'(cx_ff) + 1'b1 < eff_w) begin
                     cx_in = cx_ff + 1'b1;
                  end else begin
                     state_in = gbbd_pkg::S_DONE;
                  end
               end
            end
         end

         gbbd_pkg::S_DONE: begin
            if (rsp_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = '0;
               rsp_tuser_in  = 1'b1;
               state_in      = gbbd_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = gbbd_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= gbbd_pkg::S_CLEAR;
         sweep_ff      <= '0;
         rsp_tvalid_ff <= 1'b0;
         width_ff      <= gbbd_pkg::CFG_W'(32);
         height_ff     <= gbbd_pkg::CFG_W'(32);
      end else begin
         state_ff      <= state_in;
         sweep_ff      <= sweep_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         if (csr_valid && csr_index == gbbd_pkg::REG_GRID_WIDTH) begin
            width_ff <= csr_data;
         end
         if (csr_valid && csr_index == gbbd_pkg::REG_GRID_HEIGHT) begin
            height_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      copy_pend_ff <= copy_pend_in;
      copy_addr_ff <= copy_addr_in;
      hit_ff       <= hit_in;
      cx_ff        <= cx_in;
      cy_ff        <= cy_in;
      dxi_ff       <= dxi_in;
      dyi_ff       <= dyi_in;
      pend_ff      <= pend_in;
      sum_ff       <= sum_in;
      cnt_ff       <= cnt_in;
      quo_ff       <= quo_in;
      step_ff      <= step_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
   end

   // Light memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (light_we) begin
         light_mem[light_waddr] <= light_wdata;
      end
      if (light_re) begin
         light_rd_ff <= light_mem[light_raddr];
      end
   end

   // Snapshot memory: written only by the copy sweep.
   always_ff @(posedge clock) begin
      if (snap_we) begin
         snap_mem[snap_waddr] <= light_rd_ff;
      end
      if (snap_re) begin
         snap_rd_ff <= snap_mem[snap_raddr];
      end
   end

endmodule
